@@ design/naive_bayes_count_trainer_assert.svh @@
// assertion macros for the count trainer
`ifndef NAIVE_BAYES_COUNT_TRAINER_ASSERT_SVH
`define NAIVE_BAYES_COUNT_TRAINER_ASSERT_SVH
`ifndef SYNTHESIS
// property checked at every clock edge outside reset
`define NBCT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition that must never hold
`define NBCT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define NBCT_ASSERT(lbl, prop, msg)
`define NBCT_NEVER(lbl, cond, msg)
`endif
`endif

@@ design/nbct_pkg.sv @@
package nbct_pkg;

    localparam int DEF_MAX_CLASSES   = 16;
    localparam int DEF_MAX_FEATURES  = 16;
    localparam int DEF_MAX_VALUES    = 16;
    localparam int DEF_COUNT_WIDTH   = 32;
    localparam int DEF_FRACTION_BITS = 16;

    // config register and field widths
    localparam int CFG_W  = 5;
    localparam int IDX_W  = 2;
    localparam int ELEM_W = 4;
    // wide enough for any limit up to 256
    localparam int LIM_W  = 9;

    // register indexes
    localparam logic [IDX_W-1:0] REG_CLASS_COUNT   = 2'd0;
    localparam logic [IDX_W-1:0] REG_FEATURE_COUNT = 2'd1;
    localparam logic [IDX_W-1:0] REG_VALUE_COUNT   = 2'd2;

    // reset values of the registers
    localparam logic [CFG_W-1:0] RST_CLASS_COUNT   = 5'd2;
    localparam logic [CFG_W-1:0] RST_FEATURE_COUNT = 5'd16;
    localparam logic [CFG_W-1:0] RST_VALUE_COUNT   = 5'd16;

    typedef enum logic [1:0] {
        FUNC_ELEM  = 2'd0,
        FUNC_PRIOR = 2'd1,
        FUNC_COND  = 2'd2,
        FUNC_CLEAR = 2'd3
    } func_t;

    // clamp a register value into lo..hi
    function automatic logic [LIM_W-1:0] clamp_lim(input logic [CFG_W-1:0] v,
                                                   input logic [LIM_W-1:0] lo,
                                                   input logic [LIM_W-1:0] hi);
        logic [LIM_W-1:0] w;
        w = LIM_W'(v);
        if (w < lo)
        begin
            return lo;
        end
        if (w > hi)
        begin
            return hi;
        end
        return w;
    endfunction

endpackage

@@ design/naive_bayes_count_trainer.sv @@
// channel   | ports                                           | handshake
// ----------+-------------------------------------------------+------------------------
// request   | func element_value row_selected query_class     | start high, busy low
//           | query_feature query_value                       |
// result    | probability status row_done                     | done, one cycle
// config    | cfg_index cfg_data                              | cfg_write, no wait
//
// a feature element, an unselected label or a rejected request is accepted and
// its result registered; a selected label walks the value tally memory at one read
// and one write per cycle, over the clamped feature count; queries run the shared
// radix-2 divider. clear and reset sweep the tally memory one entry per cycle over
// all 2**(clog2 classes + clog2 features + clog2 values) entries (4096 by default),
// with busy high. results cannot be stalled.
module naive_bayes_count_trainer #(
    parameter int MAX_CLASSES   = nbct_pkg::DEF_MAX_CLASSES,
    parameter int MAX_FEATURES  = nbct_pkg::DEF_MAX_FEATURES,
    parameter int MAX_VALUES    = nbct_pkg::DEF_MAX_VALUES,
    parameter int COUNT_WIDTH   = nbct_pkg::DEF_COUNT_WIDTH,
    parameter int FRACTION_BITS = nbct_pkg::DEF_FRACTION_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    output logic                          done,
    input  logic                          cfg_write,
    input  logic [nbct_pkg::IDX_W-1:0]    cfg_index,
    input  logic [nbct_pkg::CFG_W-1:0]    cfg_data,
    input  logic [1:0]                    func,
    input  logic [nbct_pkg::ELEM_W-1:0]   element_value,
    input  logic                          row_selected,
    input  logic [nbct_pkg::ELEM_W-1:0]   query_class,
    input  logic [nbct_pkg::ELEM_W-1:0]   query_feature,
    input  logic [nbct_pkg::ELEM_W-1:0]   query_value,
    output logic [FRACTION_BITS:0]        probability,
    output logic                          status,
    output logic                          row_done
);

    import nbct_pkg::*;

    `include "naive_bayes_count_trainer_assert.svh"

    localparam int CW = $clog2(MAX_CLASSES);
    localparam int FW = $clog2(MAX_FEATURES);
    localparam int VW = $clog2(MAX_VALUES);
    localparam int AW = CW + FW + VW;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_UPD,
        S_PRIOR,
        S_QRD,
        S_DIV
    } state_t;

    state_t state_reg;

    logic [CFG_W-1:0] class_count_reg;
    logic [CFG_W-1:0] feature_count_reg;
    logic [CFG_W-1:0] value_count_reg;

    logic [LIM_W-1:0] cc_lim;
    logic [LIM_W-1:0] fc_lim;
    logic [LIM_W-1:0] vc_lim;
    logic [LIM_W-1:0] fc_m1;

    logic [FW-1:0]          pos_reg;
    logic [FW-1:0]          k_reg;
    logic [CW-1:0]          cls_reg;
    logic [AW-1:0]          sweep_reg;
    logic [AW-1:0]          wr_addr_reg;
    logic                   clr_item_reg;
    logic [COUNT_WIDTH-1:0] rows_reg;
    logic [COUNT_WIDTH-1:0] class_tally [MAX_CLASSES];
    logic [ELEM_W-1:0]      row_buf [2**FW];

    logic                   done_reg;
    logic [FRACTION_BITS:0] prob_reg;
    logic                   status_reg;
    logic                   row_done_reg;

    logic                   accept;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [COUNT_WIDTH-1:0] mem_wdata;
    logic [AW-1:0]          mem_raddr;
    logic [COUNT_WIDTH-1:0] mem_rdata;
    logic [COUNT_WIDTH-1:0] ct_sel;
    logic                   div_start;
    logic [COUNT_WIDTH-1:0] div_num;
    logic [COUNT_WIDTH-1:0] div_den;
    logic                   div_done;
    logic [FRACTION_BITS:0] div_quot;
    logic                   feat_slot;
    logic                   k_issue;
    logic                   q_bad;

    // clamped limits
    assign cc_lim = clamp_lim(class_count_reg, LIM_W'(1), LIM_W'(MAX_CLASSES));
    assign fc_lim = clamp_lim(feature_count_reg, LIM_W'(2), LIM_W'(MAX_FEATURES));
    assign vc_lim = clamp_lim(value_count_reg, LIM_W'(1), LIM_W'(MAX_VALUES));
    assign fc_m1  = fc_lim - LIM_W'(1);

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign feat_slot = LIM_W'(pos_reg) < fc_m1;
    assign k_issue   = LIM_W'(k_reg) < fc_m1;
    assign q_bad     = (LIM_W'(query_class) >= cc_lim) || (LIM_W'(query_feature) >= fc_lim)
                       || (LIM_W'(query_value) >= vc_lim);
    assign ct_sel    = class_tally[cls_reg];

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_count_reg   <= RST_CLASS_COUNT;
            feature_count_reg <= RST_FEATURE_COUNT;
            value_count_reg   <= RST_VALUE_COUNT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_CLASS_COUNT:   class_count_reg   <= cfg_data;
                REG_FEATURE_COUNT: feature_count_reg <= cfg_data;
                REG_VALUE_COUNT:   value_count_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    // tally memory port selection
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = sweep_reg;
        mem_wdata = '0;
        mem_raddr = {CW'(query_class), FW'(query_feature), VW'(query_value)};
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
            end
            S_UPD:
            begin
                mem_raddr = {cls_reg, k_reg, VW'(row_buf[k_reg])};
                if (k_reg != '0)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = wr_addr_reg;
                    mem_wdata = (mem_rdata == '1) ? mem_rdata : mem_rdata + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // divider operands
    always_comb
    begin
        div_start = 1'b0;
        div_num   = ct_sel;
        div_den   = rows_reg;
        unique case (state_reg)
            S_PRIOR:
            begin
                div_start = (rows_reg != '0);
            end
            S_QRD:
            begin
                div_start = 1'b1;
                div_num   = mem_rdata;
                div_den   = (ct_sel == '0) ? COUNT_WIDTH'(1) : ct_sel;
            end
            default: ;
        endcase
    end

    // row buffer, written in order
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && accept && func_t'(func) == FUNC_ELEM && feat_slot
            && LIM_W'(element_value) < vc_lim)
        begin
            row_buf[pos_reg] <= element_value;
        end
    end

    // sequencer, counts and registered results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            sweep_reg    <= '0;
            clr_item_reg <= 1'b0;
            pos_reg      <= '0;
            k_reg        <= '0;
            cls_reg      <= '0;
            rows_reg     <= '0;
            done_reg     <= 1'b0;
            prob_reg     <= '0;
            status_reg   <= 1'b0;
            row_done_reg <= 1'b0;
            wr_addr_reg  <= '0;
            for (int i = 0; i < MAX_CLASSES; i++)
            begin
                class_tally[i] <= '0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_reg == '1)
                    begin
                        state_reg    <= S_IDLE;
                        done_reg     <= clr_item_reg;
                        prob_reg     <= '0;
                        status_reg   <= 1'b0;
                        row_done_reg <= 1'b0;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        prob_reg     <= '0;
                        status_reg   <= 1'b0;
                        row_done_reg <= 1'b0;
                        unique case (func_t'(func))
                            FUNC_ELEM:
                            begin
                                done_reg <= 1'b1;
                                if (feat_slot)
                                begin
                                    if (LIM_W'(element_value) >= vc_lim)
                                    begin
                                        status_reg <= 1'b1;
                                    end
                                    else
                                    begin
                                        pos_reg <= pos_reg + 1'b1;
                                    end
                                end
                                else if (LIM_W'(element_value) >= cc_lim)
                                begin
                                    status_reg <= 1'b1;
                                end
                                else
                                begin
                                    rows_reg     <= (rows_reg == '1) ? rows_reg
                                                                     : rows_reg + 1'b1;
                                    pos_reg      <= '0;
                                    row_done_reg <= 1'b1;
                                    if (row_selected)
                                    begin
                                        done_reg  <= 1'b0;
                                        cls_reg   <= CW'(element_value);
                                        k_reg     <= '0;
                                        state_reg <= S_UPD;
                                    end
                                end
                            end
                            FUNC_PRIOR:
                            begin
                                if (LIM_W'(query_class) >= cc_lim)
                                begin
                                    status_reg <= 1'b1;
                                    done_reg   <= 1'b1;
                                end
                                else
                                begin
                                    cls_reg   <= CW'(query_class);
                                    state_reg <= S_PRIOR;
                                end
                            end
                            FUNC_COND:
                            begin
                                if (q_bad)
                                begin
                                    status_reg <= 1'b1;
                                    done_reg   <= 1'b1;
                                end
                                else
                                begin
                                    cls_reg   <= CW'(query_class);
                                    state_reg <= S_QRD;
                                end
                            end
                            FUNC_CLEAR:
                            begin
                                pos_reg      <= '0;
                                rows_reg     <= '0;
                                sweep_reg    <= '0;
                                clr_item_reg <= 1'b1;
                                state_reg    <= S_CLEAR;
                                for (int i = 0; i < MAX_CLASSES; i++)
                                begin
                                    class_tally[i] <= '0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_UPD:
                begin
                    // class tally on the first step, then read k / write k-1
                    if (k_reg == '0)
                    begin
                        class_tally[cls_reg] <= (ct_sel == '1) ? ct_sel : ct_sel + 1'b1;
                    end
                    wr_addr_reg <= mem_raddr;
                    k_reg       <= k_reg + 1'b1;
                    if (!k_issue)
                    begin
                        state_reg <= S_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                S_PRIOR:
                begin
                    if (rows_reg == '0)
                    begin
                        state_reg <= S_IDLE;
                        done_reg  <= 1'b1;
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_QRD:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        prob_reg  <= div_quot;
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: ;
            endcase
        end
    end

    nbct_mem #(
        .AW(AW),
        .DW(COUNT_WIDTH)
    ) u_mem (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    nbct_div #(
        .COUNT_WIDTH  (COUNT_WIDTH),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .num  (div_num),
        .den  (div_den),
        .done (div_done),
        .quot (div_quot)
    );

    assign done        = done_reg;
    assign probability = prob_reg;
    assign status      = status_reg;
    assign row_done    = row_done_reg;

    // checks
    `NBCT_NEVER(a_status_zero_prob, done && status && (probability != '0), "rejected with prob")
    `NBCT_NEVER(a_row_done_ok, row_done && status && done, "row done on rejected request")
    `NBCT_NEVER(a_prob_cap, probability[FRACTION_BITS] && (probability[FRACTION_BITS-1:0] != '0), "prob above one")
    `NBCT_ASSERT(a_clear_busy, accept && (func == FUNC_CLEAR) |=> busy, "clear did not sweep")

endmodule

@@ design/nbct_mem.sv @@
module nbct_mem #(
    parameter int AW = 12,
    parameter int DW = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rdata_reg;

    // one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/nbct_div.sv @@
module nbct_div #(
    parameter int COUNT_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [COUNT_WIDTH-1:0]   num,
    input  logic [COUNT_WIDTH-1:0]   den,
    output logic                     done,
    output logic [FRACTION_BITS:0]   quot
);

    localparam int CNT_W = $clog2(FRACTION_BITS + 1);

    logic                   run_reg;
    logic                   done_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [COUNT_WIDTH-1:0] rem_reg;
    logic [COUNT_WIDTH-1:0] den_reg;
    logic [FRACTION_BITS:0] quot_reg;
    logic [COUNT_WIDTH:0]   rem2;
    logic                   take;

    // one quotient bit per step
    assign rem2 = {rem_reg, 1'b0};
    assign take = rem2 >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                den_reg <= den;
                if (num >= den)
                begin
                    quot_reg <= {1'b1, {FRACTION_BITS{1'b0}}};
                    done_reg <= 1'b1;
                end
                else
                begin
                    rem_reg  <= num;
                    quot_reg <= '0;
                    cnt_reg  <= CNT_W'(FRACTION_BITS);
                    run_reg  <= 1'b1;
                end
            end
            else if (run_reg)
            begin
                if (take)
                begin
                    rem_reg  <= COUNT_WIDTH'(rem2 - {1'b0, den_reg});
                    quot_reg <= {quot_reg[FRACTION_BITS-1:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem2[COUNT_WIDTH-1:0];
                    quot_reg <= {quot_reg[FRACTION_BITS-1:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule
